/* src/rkc_pkg.sv */
`default_nettype none

package rkc_pkg;

  localparam int ALPHA_SIZE = 95;
  localparam int IDX_W      = 7;
  localparam int CHAR_W     = 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHA_SIZE - 1);
  localparam logic [IDX_W-1:0] NO_SYM   = IDX_W'(ALPHA_SIZE);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_IDLE    = 2'd3
  } rkc_op_t;

  // control carried alongside the table read
  typedef struct packed {
    logic             decrypt;
    logic             bad;
    logic [IDX_W-1:0] sym;
  } rkc_s1_t;

  // symbol order: A-Z, a-z, 0-9, then punctuation, space last
  function automatic logic [CHAR_W-1:0] symbol_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = 8'h00;
    if (idx < 7'd26) begin
      c = 8'h41 + {1'b0, idx};
    end else if (idx < 7'd52) begin
      c = 8'h61 + {1'b0, idx - 7'd26};
    end else if (idx < 7'd62) begin
      c = 8'h30 + {1'b0, idx - 7'd52};
    end else begin
      case (idx)
        7'd62: c = 8'h21;  // !
        7'd63: c = 8'h40;  // @
        7'd64: c = 8'h23;  // #
        7'd65: c = 8'h24;  // $
        7'd66: c = 8'h25;  // %
        7'd67: c = 8'h5E;  // ^
        7'd68: c = 8'h26;  // &
        7'd69: c = 8'h2A;  // *
        7'd70: c = 8'h28;  // (
        7'd71: c = 8'h29;  // )
        7'd72: c = 8'h7E;  // ~
        7'd73: c = 8'h60;  // `
        7'd74: c = 8'h2D;  // -
        7'd75: c = 8'h5F;  // _
        7'd76: c = 8'h3D;  // =
        7'd77: c = 8'h2B;  // +
        7'd78: c = 8'h5B;  // [
        7'd79: c = 8'h5D;  // ]
        7'd80: c = 8'h7B;  // {
        7'd81: c = 8'h7D;  // }
        7'd82: c = 8'h3B;  // ;
        7'd83: c = 8'h3A;  // :
        7'd84: c = 8'h27;  // single quote
        7'd85: c = 8'h22;  // double quote
        7'd86: c = 8'h3C;  // <
        7'd87: c = 8'h3E;  // >
        7'd88: c = 8'h2C;  // ,
        7'd89: c = 8'h2E;  // .
        7'd90: c = 8'h2F;  // /
        7'd91: c = 8'h3F;  // ?
        7'd92: c = 8'h5C;  // backslash
        7'd93: c = 8'h7C;  // |
        7'd94: c = 8'h20;  // space
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // NO_SYM when the byte is outside the alphabet
  function automatic logic [IDX_W-1:0] symbol_index(input logic [CHAR_W-1:0] ch);
    logic [IDX_W-1:0] k;
    k = NO_SYM;
    if (ch inside {[8'h41:8'h5A]}) begin
      k = IDX_W'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      k = IDX_W'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      k = IDX_W'(ch - 8'h30 + 8'd52);
    end else begin
      case (ch)
        8'h21: k = 7'd62;
        8'h40: k = 7'd63;
        8'h23: k = 7'd64;
        8'h24: k = 7'd65;
        8'h25: k = 7'd66;
        8'h5E: k = 7'd67;
        8'h26: k = 7'd68;
        8'h2A: k = 7'd69;
        8'h28: k = 7'd70;
        8'h29: k = 7'd71;
        8'h7E: k = 7'd72;
        8'h60: k = 7'd73;
        8'h2D: k = 7'd74;
        8'h5F: k = 7'd75;
        8'h3D: k = 7'd76;
        8'h2B: k = 7'd77;
        8'h5B: k = 7'd78;
        8'h5D: k = 7'd79;
        8'h7B: k = 7'd80;
        8'h7D: k = 7'd81;
        8'h3B: k = 7'd82;
        8'h3A: k = 7'd83;
        8'h27: k = 7'd84;
        8'h22: k = 7'd85;
        8'h3C: k = 7'd86;
        8'h3E: k = 7'd87;
        8'h2C: k = 7'd88;
        8'h2E: k = 7'd89;
        8'h2F: k = 7'd90;
        8'h3F: k = 7'd91;
        8'h5C: k = 7'd92;
        8'h7C: k = 7'd93;
        8'h20: k = 7'd94;
        default: k = NO_SYM;
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/running_key_char_cipher.sv */
// A character result passes the table read register (rd_data, s1_ctl), then the output register, onto m_axis.
// Throughput: one transaction per cycle while m_axis accepts; output back-pressure can drop s_axis_tready.
// Load transactions write the shift table in their cycle and give no result.
// Reset (rst, synchronous, active high) clears the table position and all valid flags;
// the shift table itself is not cleared and must be loaded before use.
`default_nettype none

module running_key_char_cipher
  import rkc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] in_char, [14:8] entry_index, [21:15] entry_value, [23:22] zero
  input  wire logic [23:0] s_axis_tdata,
  // [1:0] op, [2] start_of_message
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_char
  output logic [7:0]       m_axis_tdata,
  // [0] bad_char
  output logic             m_axis_tuser
);

  rkc_op_t          op;
  logic             som;
  logic [CHAR_W-1:0] in_char;
  logic [IDX_W-1:0] entry_index;
  logic [IDX_W-1:0] entry_value;

  assign op          = rkc_op_t'(s_axis_tuser[1:0]);
  assign som         = s_axis_tuser[2];
  assign in_char     = s_axis_tdata[7:0];
  assign entry_index = s_axis_tdata[14:8];
  assign entry_value = s_axis_tdata[21:15];

  logic accept;
  logic is_char;
  logic is_load;
  logic ready;

  assign s_axis_tready = ready;
  assign accept  = s_axis_tvalid && ready;
  assign is_char = (op == OP_ENCRYPT) || (op == OP_DECRYPT);
  assign is_load = (op == OP_LOAD);

  // Running key position. Always held in 0..94, so no clamp on read.
  logic [IDX_W-1:0] table_position;
  logic [IDX_W-1:0] pos_cur;
  logic [IDX_W-1:0] table_position_next;

  assign pos_cur             = som ? '0 : table_position;
  assign table_position_next = (pos_cur == LAST_IDX) ? '0 : pos_cur + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_position <= '0;
    end else if (accept && is_char) begin
      table_position <= table_position_next;
    end
  end

  // Table write and read never hit the same edge (one transaction per cycle),
  // and a write is visible to a read issued the next cycle, so no bypass.
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] shift_raw;

  assign wr_en = accept && is_load && (entry_index < NO_SYM);
  assign rd_en = accept && is_char;

  rkc_shift_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_index),
    .wr_data (entry_value),
    .rd_en   (rd_en),
    .rd_addr (pos_cur),
    .rd_data (shift_raw)
  );

  // Symbol lookup is done alongside the table read.
  rkc_s1_t issue_ctl;

  always_comb begin
    issue_ctl.sym     = symbol_index(in_char);
    issue_ctl.bad     = (issue_ctl.sym == NO_SYM);
    issue_ctl.decrypt = (op == OP_DECRYPT);
  end

  rkc_result_stage u_result (
    .clk         (clk),
    .rst         (rst),
    .issue       (rd_en),
    .issue_ctl   (issue_ctl),
    .shift_raw   (shift_raw),
    .issue_ready (ready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_char    (m_axis_tdata),
    .out_bad     (m_axis_tuser)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    table_position <= LAST_IDX)
    else $error("table position out of range");

  a_load_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_char) |=> $stable(table_position))
    else $error("non-character transaction moved the table position");

  a_som_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && is_char && som) |=> (table_position == IDX_W'(1)))
    else $error("start of message did not restart position");

endmodule

`default_nettype wire

/* src/rkc_shift_table.sv */
`default_nettype none

module rkc_shift_table
  import rkc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [IDX_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [0:ALPHA_SIZE-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds between reads so a stalled stage keeps its shift
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/rkc_result_stage.sv */
`default_nettype none

module rkc_result_stage
  import rkc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              issue,
  input  wire rkc_s1_t           issue_ctl,
  input  wire logic [IDX_W-1:0]  shift_raw,
  output logic                   issue_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [CHAR_W-1:0] out_char,
  output logic                   out_bad
);

  logic             s1_valid;
  rkc_s1_t          s1_ctl;
  logic             advance;
  logic [IDX_W-1:0] shift;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] res;
  logic [CHAR_W-1:0] char_next;

  assign advance     = s1_valid && (!out_valid || out_ready);
  assign issue_ready = !s1_valid || advance;

  always_comb begin
    shift = (shift_raw >= NO_SYM) ? shift_raw - NO_SYM : shift_raw;
    if (s1_ctl.decrypt) begin
      if (s1_ctl.sym >= shift) begin
        sum = {1'b0, s1_ctl.sym - shift};
      end else begin
        sum = {1'b0, s1_ctl.sym} + {1'b0, NO_SYM} - {1'b0, shift};
      end
    end else begin
      sum = {1'b0, s1_ctl.sym} + {1'b0, shift};
    end
    res = (sum >= {1'b0, NO_SYM}) ? IDX_W'(sum - {1'b0, NO_SYM}) : sum[IDX_W-1:0];
    char_next = s1_ctl.bad ? '0 : symbol_char(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl <= issue_ctl;
    end
    if (advance) begin
      out_char <= char_next;
      out_bad  <= s1_ctl.bad;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    issue |-> (!s1_valid || advance))
    else $error("read stage overwritten while full");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> (out_char == '0))
    else $error("flagged character carries non-zero byte");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("stalled character dropped");

endmodule

`default_nettype wire

/* tb/running_key_char_cipher_tb.sv */
`timescale 1ns / 100ps

module running_key_char_cipher_tb;
  import rkc_pkg::*;

  localparam int          RAND_TXNS   = 1830;   // table fill and directed rows come on top
  localparam int          HOLD_CYCLES = 400;    // one long output hold-off to back up the pipe
  localparam int          DRAIN       = 8;      // margin after the last owed result is seen
  localparam int unsigned LIMIT       = 800000;

  // alphabet in symbol order, first symbol in the top byte
  localparam logic [8*ALPHA_SIZE-1:0] SYMBOLS = {
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "abcdefghijklmnopqrstuvwxyz",
    "0123456789",
    "!@#$%^&*()",
    "~`-_=+[]{};:'\"<>,./?\\| "
  };

  // one input transaction; typed marks a row whose result is written out by hand
  typedef struct packed {
    rkc_op_t     op;
    logic        som;
    logic [7:0]  ch;
    logic [6:0]  idx;
    logic [6:0]  val;
    logic        typed;
    logic [7:0]  exp_ch;
    logic        exp_bad;
  } cipher_txn_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
  } cipher_out_t;

  // Directed rows, run after every table entry has been loaded once.
  localparam int N_DIR = 23;
  localparam cipher_txn_t DIRECTED [0:N_DIR-1] = '{
    '{OP_LOAD,    1'b0, 8'h00, 7'd0,   7'd0,   1'b0, 8'h00, 1'b0},  // zero shift
    '{OP_LOAD,    1'b0, 8'h00, 7'd1,   7'd94,  1'b0, 8'h00, 1'b0},  // largest legal shift
    '{OP_LOAD,    1'b0, 8'h00, 7'd2,   7'd127, 1'b0, 8'h00, 1'b0},  // shift taken mod 95 on use
    '{OP_LOAD,    1'b0, 8'h00, 7'd127, 7'd5,   1'b0, 8'h00, 1'b0},  // index out of range: dropped
    '{OP_LOAD,    1'b0, 8'h00, 7'd95,  7'd1,   1'b0, 8'h00, 1'b0},  // first index out of range
    '{OP_ENCRYPT, 1'b1, "A",   7'd0,   7'd0,   1'b1, "A",   1'b0},
    '{OP_ENCRYPT, 1'b0, "A",   7'd0,   7'd0,   1'b1, " ",   1'b0},  // reaches the last symbol
    '{OP_ENCRYPT, 1'b0, "A",   7'd0,   7'd0,   1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 1'b1, "A",   7'd0,   7'd0,   1'b1, "A",   1'b0},
    '{OP_DECRYPT, 1'b0, "A",   7'd0,   7'd0,   1'b1, "B",   1'b0},  // wraps below zero
    '{OP_DECRYPT, 1'b0, " ",   7'd0,   7'd0,   1'b0, 8'h00, 1'b0},
    '{OP_ENCRYPT, 1'b1, 8'h00, 7'd0,   7'd0,   1'b1, 8'h00, 1'b1},  // not in alphabet
    '{OP_ENCRYPT, 1'b0, 8'hFF, 7'd0,   7'd0,   1'b1, 8'h00, 1'b1},
    '{OP_DECRYPT, 1'b0, 8'h7F, 7'd0,   7'd0,   1'b1, 8'h00, 1'b1},
    '{OP_IDLE,    1'b1, "Q",   7'd3,   7'd9,   1'b0, 8'h00, 1'b0},  // unused op, no result
    '{OP_ENCRYPT, 1'b1, " ",   7'd0,   7'd0,   1'b1, " ",   1'b0},
    '{OP_ENCRYPT, 1'b0, "|",   7'd0,   7'd0,   1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 1'b1, "~",   7'd0,   7'd0,   1'b1, "~",   1'b0},
    '{OP_LOAD,    1'b1, "Q",   7'd94,  7'd94,  1'b0, 8'h00, 1'b0},  // som on a load is ignored
    '{OP_ENCRYPT, 1'b0, "z",   7'd0,   7'd0,   1'b0, 8'h00, 1'b0},
    '{OP_ENCRYPT, 1'b0, "0",   7'd0,   7'd0,   1'b0, 8'h00, 1'b0},
    '{OP_ENCRYPT, 1'b0, "9",   7'd0,   7'd0,   1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 1'b1, "Z",   7'd0,   7'd0,   1'b1, "Z",   1'b0}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] in_char, [14:8] entry_index, [21:15] entry_value, [23:22] zero
  logic [23:0] s_axis_tdata  = '0;
  // [1:0] op, [2] start_of_message
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] out_char
  logic [7:0]  m_axis_tdata;
  // [0] bad_char
  logic        m_axis_tuser;

  // predictor state: its own copy of the shift table and the key position
  logic [6:0]  shift_mem [0:ALPHA_SIZE-1];
  logic [6:0]  key_pos = '0;

  cipher_txn_t offered_q [$];   // offered on s_axis, not yet accepted
  cipher_out_t cipher_q  [$];   // characters owed on m_axis, oldest first

  int          fail_count = 0;
  int          rand_txns  = 0;
  bit          no_gaps    = 1'b0;
  bit          held_off   = 1'b0;
  int unsigned cycle_cnt  = 0;

  running_key_char_cipher i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] alpha_char(input int k);
    return SYMBOLS[8*(ALPHA_SIZE-1-k) +: 8];
  endfunction

  // ALPHA_SIZE when the byte has no symbol
  function automatic int alpha_index(input logic [7:0] ch);
    int k;
    for (k = 0; k < ALPHA_SIZE; k++) begin
      if (alpha_char(k) == ch) return k;
    end
    return ALPHA_SIZE;
  endfunction

  // mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 88) return alpha_char($urandom_range(0, ALPHA_SIZE - 1));
    if (r < 95) return 8'($urandom_range(0, 255));
    do c = 8'($urandom_range(0, 255)); while (alpha_index(c) != ALPHA_SIZE);
    return c;
  endfunction

  // index and value are don't-care on a character, so randomise them
  function automatic cipher_txn_t char_txn(input rkc_op_t op, input logic som,
                                           input logic [7:0] ch);
    return '{op, som, ch, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
             1'b0, 8'h00, 1'b0};
  endfunction

  function automatic cipher_txn_t load_txn(input logic [6:0] idx, input logic [6:0] val);
    return '{OP_LOAD, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), idx, val,
             1'b0, 8'h00, 1'b0};
  endfunction

  // Predictor: applies one accepted transaction to the local state and
  // returns the character it owes, if any.
  task automatic run_cipher(input rkc_op_t op, input logic som, input logic [7:0] ch,
                            input logic [6:0] idx, input logic [6:0] val,
                            output logic has, output cipher_out_t res);
    int sym;
    int sh;
    has = 1'b0;
    res = '0;
    case (op)
      OP_LOAD: begin
        if (idx < ALPHA_SIZE) shift_mem[idx] = val;
      end
      OP_ENCRYPT, OP_DECRYPT: begin
        if (som) key_pos = '0;
        sh  = int'(shift_mem[key_pos]) % ALPHA_SIZE;
        sym = alpha_index(ch);
        has = 1'b1;
        if (sym == ALPHA_SIZE) begin
          res.bad = 1'b1;
        end else if (op == OP_ENCRYPT) begin
          res.ch = alpha_char((sym + sh) % ALPHA_SIZE);
        end else begin
          res.ch = alpha_char((sym + ALPHA_SIZE - sh) % ALPHA_SIZE);
        end
        // position moves on even for a bad character
        key_pos = (key_pos == LAST_IDX) ? '0 : key_pos + 7'd1;
      end
      default: ;
    endcase
  endtask

  // Offer one transaction after an optional gap and hold it until accepted.
  task automatic send_txn(input cipher_txn_t t);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_q.insert(offered_q.size(), t);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {t.som, t.op};
    s_axis_tdata  <= {2'b00, t.val, t.idx, t.ch};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Both handshakes are observed here, input first, so the owed character is
  // queued before any result that could match it.
  always @(posedge clk) begin : monitor
    cipher_txn_t note;
    cipher_out_t res;
    cipher_out_t want;
    logic        has;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        note = offered_q.pop_front();
        run_cipher(rkc_op_t'(s_axis_tuser[1:0]), s_axis_tuser[2], s_axis_tdata[7:0],
                   s_axis_tdata[14:8], s_axis_tdata[21:15], has, res);
        if (has) cipher_q.insert(cipher_q.size(),
                                 note.typed ? cipher_out_t'({note.exp_ch, note.exp_bad})
                                            : res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          $error("result transaction with nothing owed: out_char %h bad_char %b",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = cipher_q.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.bad) begin
            $error("bad_char: expected %b, got %b", want.bad, m_axis_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off once the random part
  // is under way so the block fills and drops s_axis_tready.
  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && rand_txns >= 300) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int      k;
    int      n;
    int      len;
    int      r;
    rkc_op_t op;
    logic    som;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every entry written before the first character reads the table
    for (k = 0; k < ALPHA_SIZE; k++) send_txn(load_txn(7'(k), 7'($urandom_range(0, 94))));

    for (k = 0; k < N_DIR; k++) send_txn(DIRECTED[k]);

    while (rand_txns < RAND_TXNS) begin
      r       = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 4) == 0);
      if (r < 70) begin
        // message in one direction: som on the first character most of the time, rarely later
        op = ($urandom_range(0, 1) != 0) ? OP_ENCRYPT : OP_DECRYPT;
        n  = $urandom_range(0, 99);
        len = (n < 80) ? $urandom_range(1, 24) :
              (n < 95) ? $urandom_range(25, 94) : $urandom_range(95, 200);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 49) == 0)
            send_txn(char_txn(OP_IDLE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
          som = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 63) == 0);
          send_txn(char_txn(op, som, pick_char()));
          rand_txns++;
        end
      end else if (r < 88) begin
        // table rewrites between messages, some aimed past the end
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          send_txn(load_txn(($urandom_range(0, 9) == 0) ? 7'($urandom_range(95, 127))
                                                        : 7'($urandom_range(0, 94)),
                            7'($urandom_range(0, 127))));
          rand_txns++;
        end
      end else if (r < 95) begin
        // broken message: direction and restarts at random
        len = $urandom_range(1, 16);
        for (k = 0; k < len; k++) begin
          op = ($urandom_range(0, 1) != 0) ? OP_ENCRYPT : OP_DECRYPT;
          send_txn(char_txn(op, 1'($urandom_range(0, 1)), pick_char()));
          rand_txns++;
        end
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_txn(char_txn(OP_IDLE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
      end
    end

    no_gaps = 1'b0;
    s_axis_tvalid <= 1'b0;
    // let the monitor queue the last accepted character first
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* running_key_char_cipher.f */
src/rkc_pkg.sv
src/rkc_shift_table.sv
src/rkc_result_stage.sv
src/running_key_char_cipher.sv
tb/running_key_char_cipher_tb.sv
